// ----- sv/gpiq_pkg.sv -----
// Shared types, thresholds and status codes for the gamepad input qualifier.
// No dependencies; imported by gamepad_input_qualifier.
package gpiq_pkg;

	localparam int PORT_COUNT_DEF = 4;
	localparam int MASK_W         = 20;
	localparam int CNT_W          = 7;

	localparam logic [1:0] ST_GOOD = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;

	localparam logic [CNT_W-1:0] DELAY_RST = 7'd5;
	localparam logic [CNT_W-1:0] CNT_TOP   = 7'd127;

	localparam logic signed [7:0] STICK2_HI = 8'sd40;
	localparam logic signed [7:0] STICK2_LO = -8'sd40;
	localparam logic signed [7:0] MENU_HI   = 8'sd35;
	localparam logic signed [7:0] MENU_LO   = -8'sd35;
	localparam logic [7:0]        TRIG_TH   = 8'd10;

	localparam logic [1:0] SIGN_NEG  = 2'b11;
	localparam logic [1:0] SIGN_POS  = 2'b01;
	localparam logic [1:0] SIGN_NONE = 2'b00;

	typedef struct packed {
		logic [1:0]        sign;
		logic signed [7:0] last;
		logic [CNT_W-1:0]  count;
	} axis_t;

	// crossing detect, hold count and re-arm for one menu axis
	function automatic axis_t menu_axis(input logic signed [7:0] pos,
			input logic signed [7:0] last, input logic [CNT_W-1:0] count,
			input logic [CNT_W-1:0] delay);
		axis_t r;
		logic [CNT_W-1:0] c;
		r.sign = SIGN_NONE;
		c = count;
		if (pos < MENU_LO && last >= MENU_LO) begin
			r.sign = SIGN_NEG;
			c = '0;
		end
		if (pos > MENU_HI && last <= MENU_HI) begin
			r.sign = SIGN_POS;
			c = '0;
		end
		r.last = pos;
		if (pos < MENU_LO || pos > MENU_HI) begin
			if (c != CNT_TOP)
				c = c + 7'd1;
		end else begin
			c = '0;
		end
		if (c > delay) begin
			r.last = '0;
			c = '0;
		end
		r.count = c;
		return r;
	endfunction

endpackage

// ----- sv/gamepad_input_qualifier.sv -----
// Gamepad input qualifier: per-port button, trigger and menu-step edges.
// The input beat passes an input register, then a result register; the
// per-port state update sits between the two registers. One beat per cycle
// while out_ready does not hold the result register.
// Reset clears all per-port state and sets repeat_delay to 5.
// Depends on gpiq_pkg.
module gamepad_input_qualifier #(
	parameter int PORT_COUNT = gpiq_pkg::PORT_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [gpiq_pkg::CNT_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  port_index,
	input  logic [1:0]                  sample_status,
	input  logic [15:0]                 button_bits,
	input  logic signed [7:0]           main_x,
	input  logic signed [7:0]           main_y,
	input  logic signed [7:0]           second_x,
	input  logic signed [7:0]           second_y,
	input  logic [7:0]                  left_analog,
	input  logic [7:0]                  right_analog,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gpiq_pkg::MASK_W-1:0] held_mask,
	output logic [gpiq_pkg::MASK_W-1:0] pressed_mask,
	output logic [gpiq_pkg::MASK_W-1:0] released_mask,
	output logic [1:0]                  trigger_bits,
	output logic [1:0]                  trigger_pressed,
	output logic [1:0]                  trigger_released,
	output logic signed [1:0]           menu_x_sign,
	output logic signed [1:0]           menu_y_sign
);
	import gpiq_pkg::*;

	// only four ports are addressable by a two-bit index
	localparam int NPORT = (PORT_COUNT < 4) ? PORT_COUNT : 4;
	localparam int IDX_W = (NPORT > 1) ? $clog2(NPORT) : 1;

	logic [CNT_W-1:0] repeat_delay_q;

	logic [MASK_W-1:0]       prev_held_q [NPORT];
	logic [MASK_W-1:0]       st_pressed_q [NPORT];
	logic [MASK_W-1:0]       st_released_q [NPORT];
	logic [1:0]              prev_trig_q [NPORT];
	logic [3:0]              st_tedge_q [NPORT];
	logic signed [7:0]       last_x_q [NPORT];
	logic signed [7:0]       last_y_q [NPORT];
	logic [CNT_W-1:0]        hold_x_q [NPORT];
	logic [CNT_W-1:0]        hold_y_q [NPORT];
	logic [3:0]              st_signs_q [NPORT];

	logic                    valid_s1;
	logic [1:0]              port_s1;
	logic [1:0]              status_s1;
	logic [15:0]             buttons_s1;
	logic signed [7:0]       mx_s1, my_s1, sx_s1, sy_s1;
	logic [7:0]              la_s1, ra_s1;

	logic                    out_valid_q;
	logic [MASK_W-1:0]       held_q, pressed_q, released_q;
	logic [1:0]              trig_q, tpress_q, trel_q, xsign_q, ysign_q;

	logic                    out_free, advance, in_range;
	logic [IDX_W-1:0]        idx;
	logic [MASK_W-1:0]       held_n, diff_n, pressed_n, released_n;
	logic [1:0]              trig_n, tdiff_n;
	logic [3:0]              tedge_n;
	axis_t                   ax_n, ay_n;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign advance   = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign in_range  = ({30'd0, port_s1} < NPORT);
	assign idx       = port_s1[IDX_W-1:0];

	always_comb begin
		held_n = {4'd0, buttons_s1};
		if (sy_s1 < STICK2_LO) held_n[17] = 1'b1;
		if (sy_s1 > STICK2_HI) held_n[16] = 1'b1;
		if (sx_s1 < STICK2_LO) held_n[18] = 1'b1;
		if (sx_s1 > STICK2_HI) held_n[19] = 1'b1;
		diff_n     = held_n ^ prev_held_q[idx];
		pressed_n  = held_n & diff_n;
		released_n = prev_held_q[idx] & diff_n;
		trig_n     = {la_s1 > TRIG_TH, ra_s1 > TRIG_TH};
		tdiff_n    = trig_n ^ prev_trig_q[idx];
		tedge_n    = {prev_trig_q[idx] & tdiff_n, trig_n & tdiff_n};
		ax_n = menu_axis(mx_s1, last_x_q[idx], hold_x_q[idx], repeat_delay_q);
		ay_n = menu_axis(my_s1, last_y_q[idx], hold_y_q[idx], repeat_delay_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_delay_q <= DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			repeat_delay_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			port_s1    <= port_index;
			status_s1  <= sample_status;
			buttons_s1 <= button_bits;
			mx_s1      <= main_x;
			my_s1      <= main_y;
			sx_s1      <= second_x;
			sy_s1      <= second_y;
			la_s1      <= left_analog;
			ra_s1      <= right_analog;
		end
	end

	// per-port state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NPORT; i++) begin
				prev_held_q[i]   <= '0;
				st_pressed_q[i]  <= '0;
				st_released_q[i] <= '0;
				prev_trig_q[i]   <= '0;
				st_tedge_q[i]    <= '0;
				last_x_q[i]      <= '0;
				last_y_q[i]      <= '0;
				hold_x_q[i]      <= '0;
				hold_y_q[i]      <= '0;
				st_signs_q[i]    <= '0;
			end
		end else if (advance && in_range) begin
			if (status_s1 == ST_GOOD) begin
				prev_held_q[idx]   <= held_n;
				st_pressed_q[idx]  <= pressed_n;
				st_released_q[idx] <= released_n;
				prev_trig_q[idx]   <= trig_n;
				st_tedge_q[idx]    <= tedge_n;
				last_x_q[idx]      <= ax_n.last;
				last_y_q[idx]      <= ay_n.last;
				hold_x_q[idx]      <= ax_n.count;
				hold_y_q[idx]      <= ay_n.count;
				st_signs_q[idx]    <= {ay_n.sign, ax_n.sign};
			end else if (status_s1 == ST_NONE) begin
				prev_held_q[idx]   <= '0;
				st_pressed_q[idx]  <= '0;
				st_released_q[idx] <= '0;
				prev_trig_q[idx]   <= '0;
				st_tedge_q[idx]    <= '0;
				last_x_q[idx]      <= '0;
				last_y_q[idx]      <= '0;
				hold_x_q[idx]      <= '0;
				hold_y_q[idx]      <= '0;
				st_signs_q[idx]    <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (!in_range || status_s1 == ST_NONE) begin
				held_q     <= '0;
				pressed_q  <= '0;
				released_q <= '0;
				trig_q     <= '0;
				tpress_q   <= '0;
				trel_q     <= '0;
				xsign_q    <= SIGN_NONE;
				ysign_q    <= SIGN_NONE;
			end else if (status_s1 == ST_GOOD) begin
				held_q     <= held_n;
				pressed_q  <= pressed_n;
				released_q <= released_n;
				trig_q     <= trig_n;
				tpress_q   <= tedge_n[1:0];
				trel_q     <= tedge_n[3:2];
				xsign_q    <= ax_n.sign;
				ysign_q    <= ay_n.sign;
			end else begin
				// stale or reserved status: repeat stored results
				held_q     <= prev_held_q[idx];
				pressed_q  <= st_pressed_q[idx];
				released_q <= st_released_q[idx];
				trig_q     <= prev_trig_q[idx];
				tpress_q   <= st_tedge_q[idx][1:0];
				trel_q     <= st_tedge_q[idx][3:2];
				xsign_q    <= st_signs_q[idx][1:0];
				ysign_q    <= st_signs_q[idx][3:2];
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign held_mask        = held_q;
	assign pressed_mask     = pressed_q;
	assign released_mask    = released_q;
	assign trigger_bits     = trig_q;
	assign trigger_pressed  = tpress_q;
	assign trigger_released = trel_q;
	assign menu_x_sign      = xsign_q;
	assign menu_y_sign      = ysign_q;

	a_edges_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((pressed_q & released_q) == '0))
		else $error("pressed and released overlap");

	a_pressed_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((pressed_q & ~held_q) == '0 && (released_q & held_q) == '0))
		else $error("edge mask inconsistent with held mask");

	a_sign_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (xsign_q != 2'b10 && ysign_q != 2'b10))
		else $error("invalid menu sign code");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("stage one beat lost");

	a_trig_edges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((tpress_q & ~trig_q) == '0 && (trel_q & trig_q) == '0))
		else $error("trigger edges inconsistent");

endmodule

// ----- dv/tb_gamepad_input_qualifier.sv -----
// Self-checking testbench for gamepad_input_qualifier: a directed table, then random phases
// at several repeat delays; each result beat checked against the table or a local predictor.
// Depends on gpiq_pkg and gamepad_input_qualifier.
`timescale 1ns / 1ps

module tb_gamepad_input_qualifier;

	localparam int PORTS       = gpiq_pkg::PORT_COUNT_DEF;
	localparam int STICK_EDGE  = 40;
	localparam int TRIG_EDGE   = 10;
	localparam int MENU_EDGE   = 35;
	localparam int HOLD_TOP    = 127;
	localparam int N_PRESET    = 23;
	localparam int N_PHASE     = 6;
	localparam int SHOW_ERRORS = 10;

	localparam logic [1:0] ST_GOOD  = gpiq_pkg::ST_GOOD;
	localparam logic [1:0] ST_NONE  = gpiq_pkg::ST_NONE;
	localparam logic [1:0] ST_STALE = 2'd2;
	localparam logic [1:0] ST_RSVD  = 2'd3;

	localparam logic [19:0] S2_UP    = 20'h10000;
	localparam logic [19:0] S2_DOWN  = 20'h20000;
	localparam logic [19:0] S2_LEFT  = 20'h40000;
	localparam logic [19:0] S2_RIGHT = 20'h80000;

	typedef struct packed {
		logic [1:0]        port;
		logic [1:0]        status;
		logic [15:0]       buttons;
		logic signed [7:0] mx;
		logic signed [7:0] my;
		logic signed [7:0] sx;
		logic signed [7:0] sy;
		logic [7:0]        lt;
		logic [7:0]        rt;
	} sample_t;

	typedef struct packed {
		logic [19:0]       held;
		logic [19:0]       pressed;
		logic [19:0]       released;
		logic [1:0]        trig;
		logic [1:0]        trig_rise;
		logic [1:0]        trig_fall;
		logic signed [1:0] step_x;
		logic signed [1:0] step_y;
	} report_t;

	typedef struct packed {
		logic [19:0]       held;
		logic [19:0]       pressed;
		logic [19:0]       released;
		logic [1:0]        trig;
		logic [1:0]        trig_rise;
		logic [1:0]        trig_fall;
		logic signed [7:0] last_x;
		logic signed [7:0] last_y;
		logic [6:0]        hold_x;
		logic [6:0]        hold_y;
		logic signed [1:0] step_x;
		logic signed [1:0] step_y;
	} port_ctx_t;

	typedef struct packed {
		logic signed [1:0] step;
		logic signed [7:0] last;
		logic [6:0]        hold;
	} axis_upd_t;

	typedef struct packed {
		sample_t s;
		logic    typed;
		report_t want;
	} preset_t;

	typedef struct {
		logic [6:0] delay;
		int         items;
		int         hold_pct;
		int         port_max;
		int         src_gap;
		int         sink_gap;
	} phase_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [6:0]             cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [1:0]             port_index;
	logic [1:0]             sample_status;
	logic [15:0]            button_bits;
	logic signed [7:0]      main_x;
	logic signed [7:0]      main_y;
	logic signed [7:0]      second_x;
	logic signed [7:0]      second_y;
	logic [7:0]             left_analog;
	logic [7:0]             right_analog;
	logic                   out_valid;
	logic                   out_ready;
	logic [19:0]            held_mask;
	logic [19:0]            pressed_mask;
	logic [19:0]            released_mask;
	logic [1:0]             trigger_bits;
	logic [1:0]             trigger_pressed;
	logic [1:0]             trigger_released;
	logic signed [1:0]      menu_x_sign;
	logic signed [1:0]      menu_y_sign;

	port_ctx_t         ctx [PORTS];
	logic [6:0]        cur_delay;
	report_t           expected_reports [$];
	report_t           got;
	report_t           want;
	int                errors;
	int                results_seen;
	int                sink_gap_pct;
	bit                long_hold_done;
	int                n_good;
	int                n_absent;
	int                n_stale;
	int                n_steps;
	int                n_rises;
	logic [15:0]       sent_buttons [PORTS];
	logic signed [7:0] sent_mx [PORTS];
	logic signed [7:0] sent_my [PORTS];

	preset_t presets [N_PRESET] = '{
		'{'{2'd0, ST_STALE, 16'h0000, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'd0, 8'd0}, 1'b1, '0},
		'{'{2'd0, ST_GOOD, 16'hFFFF, 8'sd127, -8'sd128, 8'sd127, -8'sd128, 8'd255, 8'd255},
			1'b1, '{20'hAFFFF, 20'hAFFFF, 20'h0, 2'b11, 2'b11, 2'b00, 2'sb01, 2'sb11}},
		'{'{2'd0, ST_GOOD, 16'h0000, -8'sd128, 8'sd127, -8'sd128, 8'sd127, 8'd0, 8'd0},
			1'b0, '0},
		'{'{2'd0, ST_STALE, 16'h1234, 8'sd5, 8'sd5, 8'sd5, 8'sd5, 8'd50, 8'd50}, 1'b0, '0},
		'{'{2'd0, ST_RSVD, 16'hFFFF, -8'sd128, -8'sd128, -8'sd128, -8'sd128, 8'd255, 8'd255},
			1'b0, '0},
		'{'{2'd1, ST_GOOD, 16'h0001, 8'sd35, -8'sd35, 8'sd40, -8'sd40, 8'd10, 8'd10},
			1'b1, '{20'h00001, 20'h00001, 20'h0, 2'b00, 2'b00, 2'b00, 2'sb00, 2'sb00}},
		'{'{2'd1, ST_GOOD, 16'h8000, 8'sd36, -8'sd36, 8'sd41, -8'sd41, 8'd11, 8'd10}, 1'b0, '0},
		'{'{2'd1, ST_GOOD, 16'h8000, 8'sd36, -8'sd36, -8'sd41, 8'sd41, 8'd10, 8'd11}, 1'b0, '0},
		'{'{2'd2, ST_GOOD, 16'h0000, 8'sd127, 8'sd0, 8'sd0, 8'sd0, 8'd0, 8'd0}, 1'b0, '0},
		'{'{2'd2, ST_GOOD, 16'h0000, 8'sd127, 8'sd0, 8'sd0, 8'sd0, 8'd0, 8'd0}, 1'b0, '0},
		'{'{2'd2, ST_GOOD, 16'h0000, 8'sd127, 8'sd0, 8'sd0, 8'sd0, 8'd0, 8'd0}, 1'b0, '0},
		'{'{2'd2, ST_GOOD, 16'h0000, 8'sd127, 8'sd0, 8'sd0, 8'sd0, 8'd0, 8'd0}, 1'b0, '0},
		'{'{2'd2, ST_GOOD, 16'h0000, 8'sd127, 8'sd0, 8'sd0, 8'sd0, 8'd0, 8'd0}, 1'b0, '0},
		'{'{2'd2, ST_GOOD, 16'h0000, -8'sd128, -8'sd128, 8'sd0, 8'sd0, 8'd0, 8'd0}, 1'b0, '0},
		'{'{2'd2, ST_GOOD, 16'h0000, -8'sd128, -8'sd128, 8'sd0, 8'sd0, 8'd0, 8'd0}, 1'b0, '0},
		'{'{2'd2, ST_GOOD, 16'h0000, -8'sd128, -8'sd128, 8'sd0, 8'sd0, 8'd0, 8'd0}, 1'b0, '0},
		'{'{2'd2, ST_GOOD, 16'h0000, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'd0, 8'd0}, 1'b0, '0},
		'{'{2'd0, ST_NONE, 16'hBEEF, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'd255, 8'd255},
			1'b1, '0},
		'{'{2'd0, ST_STALE, 16'h0F0F, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'd0, 8'd0}, 1'b1, '0},
		'{'{2'd3, ST_GOOD, 16'h5555, -8'sd36, 8'sd36, 8'sd0, 8'sd0, 8'd255, 8'd0}, 1'b0, '0},
		'{'{2'd3, ST_GOOD, 16'hAAAA, -8'sd36, 8'sd36, 8'sd0, 8'sd0, 8'd0, 8'd255}, 1'b0, '0},
		'{'{2'd1, ST_NONE, 16'h0000, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'd0, 8'd0}, 1'b1, '0},
		'{'{2'd1, ST_RSVD, 16'h0000, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'd0, 8'd0}, 1'b1, '0}
	};

	gamepad_input_qualifier dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.port_index       (port_index),
		.sample_status    (sample_status),
		.button_bits      (button_bits),
		.main_x           (main_x),
		.main_y           (main_y),
		.second_x         (second_x),
		.second_y         (second_y),
		.left_analog      (left_analog),
		.right_analog     (right_analog),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.held_mask        (held_mask),
		.pressed_mask     (pressed_mask),
		.released_mask    (released_mask),
		.trigger_bits     (trigger_bits),
		.trigger_pressed  (trigger_pressed),
		.trigger_released (trigger_released),
		.menu_x_sign      (menu_x_sign),
		.menu_y_sign      (menu_y_sign)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic axis_upd_t axis_advance(int pos, int last, int hold);
		axis_upd_t u;
		int h;
		int sgn;
		int nl;
		sgn = 0;
		h = hold;
		if (pos < -MENU_EDGE && last >= -MENU_EDGE) begin
			sgn = -1;
			h = 0;
		end
		if (pos > MENU_EDGE && last <= MENU_EDGE) begin
			sgn = 1;
			h = 0;
		end
		nl = pos;
		if (pos < -MENU_EDGE || pos > MENU_EDGE) begin
			if (h < HOLD_TOP)
				h = h + 1;
		end else begin
			h = 0;
		end
		// re-arm: the next deflected sample counts as a fresh crossing
		if (h > int'(cur_delay)) begin
			nl = 0;
			h = 0;
		end
		u.step = 2'(sgn);
		u.last = 8'(nl);
		u.hold = 7'(h);
		return u;
	endfunction

	function automatic report_t ctx_report(port_ctx_t c);
		report_t r;
		r.held      = c.held;
		r.pressed   = c.pressed;
		r.released  = c.released;
		r.trig      = c.trig;
		r.trig_rise = c.trig_rise;
		r.trig_fall = c.trig_fall;
		r.step_x    = c.step_x;
		r.step_y    = c.step_y;
		return r;
	endfunction

	function automatic report_t qualify(sample_t s);
		port_ctx_t c;
		axis_upd_t ax;
		axis_upd_t ay;
		logic [19:0] held;
		logic [19:0] diff;
		logic [1:0] trig;
		logic [1:0] tdiff;
		if (int'(s.port) >= PORTS)
			return '0;
		if (s.status == ST_NONE) begin
			ctx[s.port] = '0;
			return '0;
		end
		c = ctx[s.port];
		if (s.status != ST_GOOD)
			return ctx_report(c);
		held = {4'h0, s.buttons};
		if ($signed(s.sy) < -STICK_EDGE) held |= S2_DOWN;
		if ($signed(s.sy) > STICK_EDGE)  held |= S2_UP;
		if ($signed(s.sx) < -STICK_EDGE) held |= S2_LEFT;
		if ($signed(s.sx) > STICK_EDGE)  held |= S2_RIGHT;
		diff = held ^ c.held;
		c.pressed  = held & diff;
		c.released = c.held & diff;
		c.held     = held;
		trig = {int'(s.lt) > TRIG_EDGE, int'(s.rt) > TRIG_EDGE};
		tdiff = trig ^ c.trig;
		c.trig_rise = trig & tdiff;
		c.trig_fall = c.trig & tdiff;
		c.trig      = trig;
		ay = axis_advance($signed(s.my), $signed(c.last_y), c.hold_y);
		ax = axis_advance($signed(s.mx), $signed(c.last_x), c.hold_x);
		c.last_x = ax.last;
		c.hold_x = ax.hold;
		c.step_x = ax.step;
		c.last_y = ay.last;
		c.hold_y = ay.hold;
		c.step_y = ay.step;
		ctx[s.port] = c;
		return ctx_report(c);
	endfunction

	function automatic logic signed [7:0] pick_main(logic signed [7:0] prev, int hold_pct);
		int v;
		if ($urandom_range(0, 99) < hold_pct)
			return prev;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 255);
			1: v = $urandom_range(33, 38);
			2: v = -int'($urandom_range(33, 38));
			default: v = $urandom_range(0, 1) ? 127 : -128;
		endcase
		return 8'(v);
	endfunction

	function automatic logic signed [7:0] pick_second();
		int v;
		case ($urandom_range(0, 2))
			0: v = $urandom_range(0, 255);
			1: v = $urandom_range(38, 43);
			default: v = -int'($urandom_range(38, 43));
		endcase
		return 8'(v);
	endfunction

	function automatic logic [7:0] pick_trigger();
		if ($urandom_range(0, 1))
			return 8'($urandom);
		return 8'($urandom_range(8, 13));
	endfunction

	task automatic send_sample(input sample_t s, input logic typed, input report_t fixed);
		report_t r;
		in_valid      <= 1'b1;
		port_index    <= s.port;
		sample_status <= s.status;
		button_bits   <= s.buttons;
		main_x        <= s.mx;
		main_y        <= s.my;
		second_x      <= s.sx;
		second_y      <= s.sy;
		left_analog   <= s.lt;
		right_analog  <= s.rt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = qualify(s);
		expected_reports.push_back(typed ? fixed : r);
		case (s.status)
			ST_GOOD: n_good++;
			ST_NONE: n_absent++;
			default: n_stale++;
		endcase
	endtask

	task automatic write_delay(input logic [6:0] d);
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_delay = d;
	endtask

	task automatic drain();
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic source_gap(input int pct);
		if (pct != 0 && $urandom_range(0, 99) < pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// result beats against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			got = '{held_mask, pressed_mask, released_mask, trigger_bits, trigger_pressed,
				trigger_released, menu_x_sign, menu_y_sign};
			if (got.step_x != 2'sb00 || got.step_y != 2'sb00) n_steps++;
			if (got.pressed != '0) n_rises++;
			if (expected_reports.size() == 0) begin
				errors++;
				if (errors <= SHOW_ERRORS)
					$display("unexpected result beat: held %h", held_mask);
			end else begin
				want = expected_reports.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= SHOW_ERRORS) begin
						$display("mismatch at beat %0d (exp/got):", results_seen);
						$display("  held %h/%h pressed %h/%h released %h/%h",
							want.held, got.held, want.pressed, got.pressed,
							want.released, got.released);
						$display("  trig %b/%b rise %b/%b fall %b/%b step x %0d/%0d y %0d/%0d",
							want.trig, got.trig, want.trig_rise, got.trig_rise,
							want.trig_fall, got.trig_fall, want.step_x, got.step_x,
							want.step_y, got.step_y);
					end
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off to back the block up
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!long_hold_done && results_seen >= 150) begin
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (64) @(posedge clk);
			end else if (sink_gap_pct != 0 && $urandom_range(0, 99) < sink_gap_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("gamepad_input_qualifier regression: fail");
		$finish;
	end

	initial begin
		phase_t plan [N_PHASE];
		sample_t s;
		int r;
		int none_pct;
		plan = '{
			'{7'd0,   260, 60, 3, 0,  0},
			'{7'd126, 300, 99, 0, 15, 15},
			'{7'd127, 250, 99, 0, 10, 20},
			'{7'd1,   260, 50, 3, 30, 10},
			'{7'd4,   260, 70, 3, 10, 30},
			'{7'd0,   280, 60, 3, 0,  0}
		};
		plan[N_PHASE-1].delay = 7'($urandom_range(0, 126));
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		port_index    <= '0;
		sample_status <= '0;
		button_bits   <= '0;
		main_x        <= '0;
		main_y        <= '0;
		second_x      <= '0;
		second_y      <= '0;
		left_analog   <= '0;
		right_analog  <= '0;
		errors = 0;
		results_seen = 0;
		long_hold_done = 1'b0;
		n_good = 0;
		n_absent = 0;
		n_stale = 0;
		n_steps = 0;
		n_rises = 0;
		cur_delay = gpiq_pkg::DELAY_RST;
		for (int p = 0; p < PORTS; p++) begin
			ctx[p] = '0;
			sent_buttons[p] = '0;
			sent_mx[p] = '0;
			sent_my[p] = '0;
		end
		sink_gap_pct = 10;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a short delay so that autorepeat shows within the table
		write_delay(7'd2);
		for (int i = 0; i < N_PRESET; i++) begin
			send_sample(presets[i].s, presets[i].typed, presets[i].want);
			source_gap(10);
		end
		in_valid <= 1'b0;

		for (int ph = 0; ph < N_PHASE; ph++) begin
			drain();
			write_delay(plan[ph].delay);
			sink_gap_pct = plan[ph].sink_gap;
			none_pct = (plan[ph].hold_pct >= 95) ? 0 : 4;
			for (int i = 0; i < plan[ph].items; i++) begin
				s.port = 2'($urandom_range(0, plan[ph].port_max));
				r = $urandom_range(0, 99);
				if (r < none_pct)
					s.status = ST_NONE;
				else if (r < none_pct + 6)
					s.status = ST_STALE;
				else if (r < none_pct + 9)
					s.status = ST_RSVD;
				else
					s.status = ST_GOOD;
				case ($urandom_range(0, 3))
					0: s.buttons = sent_buttons[s.port];
					1, 2: s.buttons = sent_buttons[s.port] ^ (16'h1 << $urandom_range(0, 15));
					default: s.buttons = 16'($urandom);
				endcase
				s.mx = pick_main(sent_mx[s.port], plan[ph].hold_pct);
				s.my = pick_main(sent_my[s.port], plan[ph].hold_pct);
				s.sx = pick_second();
				s.sy = pick_second();
				s.lt = pick_trigger();
				s.rt = pick_trigger();
				sent_buttons[s.port] = s.buttons;
				sent_mx[s.port] = s.mx;
				sent_my[s.port] = s.my;
				send_sample(s, 1'b0, '0);
				source_gap(plan[ph].src_gap);
			end
			in_valid <= 1'b0;
		end

		drain();
		repeat (8) @(posedge clk);
		$display("covered %0d samples: %0d good, %0d absent, %0d stale or reserved status",
			n_good + n_absent + n_stale, n_good, n_absent, n_stale);
		$display("%0d beats with a menu step, %0d with a press; delays 2 0 126 127 1 4 %0d",
			n_steps, n_rises, plan[N_PHASE-1].delay);
		if (errors == 0)
			$display("gamepad_input_qualifier regression: pass");
		else
			$display("gamepad_input_qualifier regression: fail");
		$finish;
	end

endmodule
